FILE: hdl/spsch_pkg.sv
`timescale 1ns / 1ps
package spsch_pkg;

    localparam int FIELD_W      = 16;
    localparam int SLOT_FIELD_W = 4;
    localparam int SLOT_RANGE   = 16;
    localparam int REQ_W        = 2;
    localparam int CFG_W        = 5;
    localparam int DONE_W       = 5;
    localparam int IN_DATA_W    = 72;
    localparam int OUT_DATA_W   = 88;

    localparam logic [REQ_W-1:0] REQ_LOAD    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    localparam logic [DONE_W-1:0] DONE_MAX = '1;

    typedef struct packed {
        logic                    we;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [FIELD_W-1:0]      task_id;
        logic [FIELD_W-1:0]      arrival;
        logic [FIELD_W-1:0]      burst;
        logic [FIELD_W-1:0]      task_period;
    } load_t;

    typedef struct packed {
        logic               found;
        logic [FIELD_W-1:0] task_period;
        logic [FIELD_W-1:0] arrival;
        logic [FIELD_W-1:0] task_id;
        logic [FIELD_W-1:0] burst;
        logic [FIELD_W-1:0] remaining;
    } cand_t;

endpackage

FILE: hdl/static_period_priority_scheduler.sv
`timescale 1ns / 1ps
// Fixed-priority (rate monotonic) tick scheduler. Each input word is a load, a tick or a
// restart, selected by s_tuser. Load and restart words are taken without leaving the idle
// state and give no output word. A tick word gives one output word: in state S_SCAN the
// best candidate walks the row of task cells one cell per cycle, then state S_FIN updates
// the chosen task, clock and completion count and state S_OUT forms the statistics; the
// block takes its next word once that output word is registered. Task slots that were
// never loaded have no remaining work and are never chosen. task_count lives at address 0.
module static_period_priority_scheduler #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    // slot[3:0], task_id[19:4], arrival[35:20], burst[51:36], task_period[67:52], zeros
    input  logic [spsch_pkg::IN_DATA_W-1:0]  s_tdata,
    // req_type[1:0]
    input  logic [spsch_pkg::REQ_W-1:0]      s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tick_time[15:0], idle[16], running_slot[20:17], running_id[36:21], finished[37],
    // completion_time[53:38], turnaround[69:54], waiting[85:70], all_done[86], zero
    output logic [spsch_pkg::OUT_DATA_W-1:0] m_tdata
);
    import spsch_pkg::*;

    localparam int SLOT_W = $clog2(MAX_TASKS);
    localparam int CW     = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;
    localparam int NW     = ($clog2(MAX_TASKS + 1) > CFG_W) ? $clog2(MAX_TASKS + 1) : CFG_W;
    localparam logic [TIME_BITS-1:0] TMAX = '1;
    localparam logic [SLOT_W-1:0] LAST_CNT = SLOT_W'(MAX_TASKS - 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_FIN  = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [SLOT_W-1:0]      cnt_reg;
    logic [SLOT_W-1:0]      cnt_next;
    logic [CFG_W-1:0]       tc_reg;
    logic [TIME_BITS-1:0]   clock_reg;
    logic [TIME_BITS-1:0]   clock_next;
    logic [DONE_W-1:0]      done_reg;
    logic [DONE_W-1:0]      done_next;

    logic                   found_reg;
    logic                   fin_reg;
    logic [SLOT_W-1:0]      pick_reg;
    logic [FIELD_W-1:0]     id_reg;
    logic [FIELD_W-1:0]     burst_reg;
    logic [FIELD_W-1:0]     tick_reg;
    logic [FIELD_W-1:0]     comp_reg;
    logic [CW-1:0]          tat_reg;

    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg;
    logic [OUT_DATA_W-1:0]  out_data_next;

    load_t                  load;
    logic                   in_acc;
    logic                   cfg_wr;
    logic                   out_load;
    logic                   dec;
    logic [NW-1:0]          n_eff;
    logic [TIME_BITS-1:0]   comp_w;
    logic [CW-1:0]          tat_w;
    logic [CW-1:0]          wt_w;
    logic                   fin_w;

    cand_t                  cand [MAX_TASKS+1];
    logic [SLOT_W-1:0]      cslot [MAX_TASKS+1];
    logic [MAX_TASKS-1:0]   active;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && !paddr[2];
    assign prdata   = paddr[2] ? 32'd0 : {{(32-CFG_W){1'b0}}, tc_reg};

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid && s_tready;

    assign load.we          = in_acc && (s_tuser == REQ_LOAD);
    assign load.slot        = s_tdata[3:0];
    assign load.task_id     = s_tdata[19:4];
    assign load.arrival     = s_tdata[35:20];
    assign load.burst       = s_tdata[51:36];
    assign load.task_period = s_tdata[67:52];

    assign n_eff = ({{(32-CFG_W){1'b0}}, tc_reg} > MAX_TASKS) ? NW'(MAX_TASKS) : NW'(tc_reg);
    assign dec   = (state_reg == S_FIN) && cand[MAX_TASKS].found;

    assign cand[0]  = '0;
    assign cslot[0] = '0;

    for (genvar k = 0; k < MAX_TASKS; k++)
    begin : g_cell
        assign active[k] = ({{(32-CFG_W){1'b0}}, tc_reg} > k);

        spsch_cell #(
            .TIME_BITS (TIME_BITS),
            .SLOT_W    (SLOT_W),
            .INDEX     (k)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .load     (load),
            .dec      (dec),
            .dec_slot (cslot[MAX_TASKS]),
            .active   (active[k]),
            .now      (clock_reg),
            .cand_in  (cand[k]),
            .slot_in  (cslot[k]),
            .cand_out (cand[k+1]),
            .slot_out (cslot[k+1])
        );
    end

    always_comb
    begin
        comp_w = (clock_reg == TMAX) ? clock_reg : clock_reg + 1'b1;
        tat_w  = CW'(comp_w) - CW'(cand[MAX_TASKS].arrival);
        fin_w  = cand[MAX_TASKS].found && (cand[MAX_TASKS].remaining == FIELD_W'(1));
        wt_w   = (tat_reg >= CW'(burst_reg)) ? tat_reg - CW'(burst_reg) : '0;
        out_load = (state_reg == S_OUT) && (!out_valid_reg || m_tready);

        out_data_next = {
            1'b0,
            (NW'(done_reg) >= n_eff),
            fin_reg ? FIELD_W'(wt_w) : '0,
            fin_reg ? FIELD_W'(tat_reg) : '0,
            fin_reg ? comp_reg : '0,
            fin_reg,
            found_reg ? id_reg : '0,
            found_reg ? SLOT_FIELD_W'(pick_reg) : '0,
            !found_reg,
            tick_reg
        };

        state_next = state_reg;
        cnt_next   = cnt_reg;
        clock_next = clock_reg;
        done_next  = done_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (s_tuser)
                        REQ_TICK:
                        begin
                            state_next = S_SCAN;
                            cnt_next   = '0;
                        end
                        REQ_RESTART:
                        begin
                            clock_next = '0;
                            done_next  = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_CNT)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_OUT;
                if (clock_reg != TMAX)
                begin
                    clock_next = clock_reg + 1'b1;
                end
                if (fin_w && (done_reg != DONE_MAX))
                begin
                    done_next = done_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            tc_reg        <= CFG_W'(1);
            clock_reg     <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clock_reg <= clock_next;
            done_reg  <= done_next;
            if (cfg_wr)
            begin
                tc_reg <= pwdata[CFG_W-1:0];
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FIN)
        begin
            found_reg <= cand[MAX_TASKS].found;
            fin_reg   <= fin_w;
            pick_reg  <= cslot[MAX_TASKS];
            id_reg    <= cand[MAX_TASKS].task_id;
            burst_reg <= cand[MAX_TASKS].burst;
            tick_reg  <= FIELD_W'(clock_reg);
            comp_reg  <= FIELD_W'(comp_w);
            tat_reg   <= tat_w;
        end
        if (out_load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: hdl/spsch_cell.sv
`timescale 1ns / 1ps
module spsch_cell #(
    parameter int TIME_BITS = 16,
    parameter int SLOT_W    = 4,
    parameter int INDEX     = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  spsch_pkg::load_t     load,
    input  logic                 dec,
    input  logic [SLOT_W-1:0]    dec_slot,
    input  logic                 active,
    input  logic [TIME_BITS-1:0] now,
    input  spsch_pkg::cand_t     cand_in,
    input  logic [SLOT_W-1:0]    slot_in,
    output spsch_pkg::cand_t     cand_out,
    output logic [SLOT_W-1:0]    slot_out
);
    import spsch_pkg::*;

    localparam int CW = (TIME_BITS > FIELD_W) ? TIME_BITS : FIELD_W;
    localparam logic [SLOT_W-1:0] MY_SLOT = SLOT_W'(INDEX);

    logic [FIELD_W-1:0] id_reg;
    logic [FIELD_W-1:0] arr_reg;
    logic [FIELD_W-1:0] burst_reg;
    logic [FIELD_W-1:0] period_reg;
    logic [FIELD_W-1:0] rem_reg;
    logic [FIELD_W-1:0] rem_next;
    cand_t              cand_reg;
    cand_t              cand_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;

    logic hit;
    logic eligible;
    logic beats;

    assign hit = load.we && (INDEX < SLOT_RANGE) && (load.slot == SLOT_FIELD_W'(INDEX));

    always_comb
    begin
        eligible = active && (CW'(arr_reg) <= CW'(now)) && (rem_reg != '0);
        if (period_reg != cand_in.task_period)
        begin
            beats = period_reg < cand_in.task_period;
        end
        else if (arr_reg != cand_in.arrival)
        begin
            beats = arr_reg < cand_in.arrival;
        end
        else
        begin
            beats = id_reg < cand_in.task_id;
        end

        if (eligible && (!cand_in.found || beats))
        begin
            cand_next.found       = 1'b1;
            cand_next.task_period = period_reg;
            cand_next.arrival     = arr_reg;
            cand_next.task_id     = id_reg;
            cand_next.burst       = burst_reg;
            cand_next.remaining   = rem_reg;
            slot_next             = MY_SLOT;
        end
        else
        begin
            cand_next = cand_in;
            slot_next = slot_in;
        end

        if (hit)
        begin
            rem_next = load.burst;
        end
        else if (dec && (dec_slot == MY_SLOT))
        begin
            rem_next = rem_reg - 1'b1;
        end
        else
        begin
            rem_next = rem_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            id_reg     <= load.task_id;
            arr_reg    <= load.arrival;
            burst_reg  <= load.burst;
            period_reg <= load.task_period;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            cand_reg <= '0;
            slot_reg <= '0;
        end
        else
        begin
            rem_reg  <= rem_next;
            cand_reg <= cand_next;
            slot_reg <= slot_next;
        end
    end

    assign cand_out = cand_reg;
    assign slot_out = slot_reg;

endmodule
